// ===== src/sdu_pkg.sv =====
`default_nettype none
package sdu_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 64;
  localparam int VALUE_WIDTH = 16;
  // Fixed width of the value fields on the channels
  localparam int FIELD_W     = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // Input action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic cap_load;    // capture the incoming value as the search key
    logic emit_begin;  // start a new emission run
    logic scan_start;  // rewind the store scan
    logic scan_en;     // step the store scan
    logic commit_load; // store the key if it was not found and the store has room
    logic emit_push;   // move the found minimum into the output register
  } sdu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;   // every held entry has been read and compared
    logic out_free;    // output register can take a result this cycle
    logic emit_last;   // the next pushed result ends the run
  } sdu_sts_t;

endpackage
`default_nettype wire

// ===== src/sdu_if.sv =====
`default_nettype none
// Input channel
interface sdu_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sdu_pkg::FIELD_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// Result channel
interface sdu_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdu_pkg::FIELD_W-1:0] result_value;
  logic                        last;
  logic                        empty_res;
  logic                        overflowed;

  modport source (output valid, output result_value, output last, output empty_res,
                  output overflowed, input ready);
  modport sink   (input valid, input result_value, input last, input empty_res,
                  input overflowed, output ready);
endinterface
`default_nettype wire

// ===== src/sorted_distinct_union_top.sv =====
`default_nettype none
// Load transaction: input busy during the store scan (one store read per held value, one compare
// stage, then the commit); with an empty store the scan ends at once and the load commits.
// Finish transaction with n held values: n results, each after a full store scan; an empty
// store loads its single result into the output register without a scan.
// A result waits in an output register while the next scan runs.
// Synchronous active-low reset clears fill count, overflow flag and control; store contents
// are left as they are and need no clearing pass.
module sorted_distinct_union_top (
  input wire logic   clk,
  input wire logic   rst_n,
  sdu_in_if.sink     in_if,
  sdu_out_if.source  out_if
);
  import sdu_pkg::*;

  sdu_cmd_t cmd;
  sdu_sts_t sts;

  sdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .in_ready  (in_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_if.value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_result_value (out_if.result_value),
    .out_last         (out_if.last),
    .out_empty_res    (out_if.empty_res),
    .out_overflowed   (out_if.overflowed)
  );

endmodule
`default_nettype wire

// ===== src/sdu_ctrl.sv =====
`default_nettype none
module sdu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_ready,
  output sdu_pkg::sdu_cmd_t      cmd,
  input  wire sdu_pkg::sdu_sts_t sts
);
  import sdu_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LSCAN = 2'd1;
  localparam logic [1:0] S_ESCAN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.scan_start = 1'b1;
          if (in_action == ACT_LOAD) begin
            cmd.cap_load = 1'b1;
            state_nxt    = S_LSCAN;
          end else begin
            cmd.emit_begin = 1'b1;
            state_nxt      = S_ESCAN;
          end
        end
      end
      S_LSCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          cmd.commit_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_ESCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done && sts.out_free) begin
          cmd.emit_push = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sdu_dp.sv =====
`default_nettype none
module sdu_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sdu_pkg::FIELD_W-1:0] in_value,
  input  wire sdu_pkg::sdu_cmd_t           cmd,
  output sdu_pkg::sdu_sts_t                sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sdu_pkg::FIELD_W-1:0]      out_result_value,
  output logic                             out_last,
  output logic                             out_empty_res,
  output logic                             out_overflowed
);
  import sdu_pkg::*;

  value_t mem [STORE_DEPTH];

  cnt_t   fill_r;
  logic   ovf_r;
  cnt_t   idx_r;
  logic   rv_r;
  value_t rd_data_r;
  value_t cand_r;
  logic   hit_r;
  value_t prev_r;
  logic   have_prev_r;
  value_t best_r;
  logic   best_vld_r;
  cnt_t   emit_cnt_r;

  logic                out_valid_r;
  logic [FIELD_W-1:0]  out_value_r;
  logic                out_last_r;
  logic                out_empty_r;
  logic                out_ovf_r;

  logic rd_issue;
  logic above_prev;
  logic below_best;
  logic store_empty;
  logic has_room;
  cnt_t emit_cnt_inc;

  assign rd_issue     = cmd.scan_en && (idx_r < fill_r);
  assign above_prev   = !have_prev_r || (rd_data_r > prev_r);
  assign below_best   = !best_vld_r || (rd_data_r < best_r);
  assign store_empty  = (fill_r == '0);
  assign has_room     = (fill_r < CNT_W'(STORE_DEPTH));
  assign emit_cnt_inc = CNT_W'(emit_cnt_r + 1'b1);

  assign sts.scan_done = (idx_r == fill_r) && !rv_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = store_empty || (emit_cnt_inc == fill_r);

  // Store write port
  always_ff @(posedge clk) begin
    if (cmd.commit_load && !hit_r && has_room) begin
      mem[fill_r[ADDR_W-1:0]] <= cand_r;
    end
  end

  // Store read port, registered data
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  // Scan counter and read pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= rd_issue;
      if (cmd.scan_start) begin
        idx_r <= '0;
      end else if (rd_issue) begin
        idx_r <= CNT_W'(idx_r + 1'b1);
      end
    end
  end

  // Compare stage: key match for loads, next-larger minimum for emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (rv_r) begin
      if (rd_data_r == cand_r) begin
        hit_r <= 1'b1;
      end
      if (above_prev && below_best) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r && above_prev && below_best && !cmd.scan_start) begin
      best_r <= rd_data_r;
    end
    if (cmd.cap_load) begin
      cand_r <= in_value[VALUE_WIDTH-1:0];
    end
    if (cmd.emit_push) begin
      prev_r <= best_r;
    end
  end

  // Fill count, overflow flag and emission progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      have_prev_r <= 1'b0;
      emit_cnt_r  <= '0;
    end else begin
      if (cmd.commit_load && !hit_r) begin
        if (has_room) begin
          fill_r <= CNT_W'(fill_r + 1'b1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_begin) begin
        have_prev_r <= 1'b0;
        emit_cnt_r  <= '0;
      end else if (cmd.emit_push) begin
        have_prev_r <= 1'b1;
        emit_cnt_r  <= emit_cnt_inc;
      end
      if (cmd.emit_push && sts.emit_last) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_push) begin
      out_value_r <= store_empty ? '0 : FIELD_W'(best_r);
      out_last_r  <= sts.emit_last;
      out_empty_r <= store_empty;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_empty_res    = out_empty_r;
  assign out_overflowed   = out_ovf_r;

endmodule
`default_nettype wire
